FILE: hw/rtl/tls_record_hello_metadata_parser_top_assert.svh
// Assertion macros for the TLS record parser checker.
// Depends on nothing; included by the checker file.
`ifndef TLS_RECORD_HELLO_METADATA_PARSER_TOP_ASSERT_SVH
`define TLS_RECORD_HELLO_METADATA_PARSER_TOP_ASSERT_SVH
// clocked check, off while in reset
`define TLSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlsp assertion failed");
// clocked check that also holds during reset
`define TLSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tlsp reset assertion failed");
`endif

FILE: hw/rtl/tlsp_pkg.sv
// Shared types, constants and helpers of the TLS record parser.
// No dependencies.
package tlsp_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned MaxEvents     = 4;

  localparam logic [7:0]  CtMin       = 8'd20;
  localparam logic [7:0]  CtMax       = 8'd23;
  localparam logic [7:0]  CtHandshake = 8'd22;
  localparam logic [15:0] ExtSupVer   = 16'h002b;
  localparam logic [15:0] ExtAlpn     = 16'h0010;
  localparam logic [15:0] ExtSni      = 16'h0000;
  localparam logic [23:0] ChMin       = 24'(2 + 32 + 1);
  localparam logic [23:0] ShMin       = 24'(2 + 32 + 1 + 2 + 1);
  localparam logic [7:0]  MsgClientHello = 8'd1;
  localparam logic [7:0]  MsgServerHello = 8'd2;
  localparam logic [15:0] SniLimit    = 16'd256;
  localparam logic [7:0]  AlpnLimit   = 8'd64;

  typedef enum logic [2:0] {
    EV_RECORD  = 3'd0,
    EV_SNI     = 3'd1,
    EV_ALPN    = 3'd2,
    EV_CHELLO  = 3'd3,
    EV_SHELLO  = 3'd4,
    EV_STOP    = 3'd5,
    EV_PKTDONE = 3'd6
  } ev_kind_e;

  typedef enum logic [30:0] {
    PH_HDR      = 31'd1 << 0,
    PH_DRAIN    = 31'd1 << 1,
    PH_RSKIP    = 31'd1 << 2,
    PH_HHDR     = 31'd1 << 3,
    PH_HSKIP    = 31'd1 << 4,
    PH_MSKIP    = 31'd1 << 5,
    PH_CFIX     = 31'd1 << 6,
    PH_CSIDLEN  = 31'd1 << 7,
    PH_CSID     = 31'd1 << 8,
    PH_CCSLEN   = 31'd1 << 9,
    PH_CCS      = 31'd1 << 10,
    PH_CCOMPLEN = 31'd1 << 11,
    PH_CCOMP    = 31'd1 << 12,
    PH_CEXTLEN  = 31'd1 << 13,
    PH_SVER     = 31'd1 << 14,
    PH_SRAND    = 31'd1 << 15,
    PH_SSIDLEN  = 31'd1 << 16,
    PH_SSID     = 31'd1 << 17,
    PH_SCIPH    = 31'd1 << 18,
    PH_SCOMP    = 31'd1 << 19,
    PH_SEXTLEN  = 31'd1 << 20,
    PH_XHDR     = 31'd1 << 21,
    PH_XSKIP    = 31'd1 << 22,
    PH_NLIST    = 31'd1 << 23,
    PH_NTYPE    = 31'd1 << 24,
    PH_NLEN     = 31'd1 << 25,
    PH_NNAME    = 31'd1 << 26,
    PH_ALIST    = 31'd1 << 27,
    PH_ALEN     = 31'd1 << 28,
    PH_ANAME    = 31'd1 << 29,
    PH_VSEL     = 31'd1 << 30
  } phase_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  ct;
    logic [23:0] len;
    logic [7:0]  nb;
    logic        fits;
    logic        reason;
  } ev_t;

  typedef struct packed {
    ev_t [MaxEvents-1:0] ev;
    logic [2:0]          cnt;
    logic [15:0]         ver;
    logic [15:0]         ciph;
    logic [2:0]          flags;
  } bundle_t;

  function automatic bundle_t push_ev(bundle_t b, ev_kind_e kind, logic [7:0] ct,
                                      logic [23:0] len, logic [7:0] nb,
                                      logic fits, logic reason);
    bundle_t r;
    r = b;
    if (r.cnt < 3'(MaxEvents)) begin
      r.ev[r.cnt[1:0]].kind   = kind;
      r.ev[r.cnt[1:0]].ct     = ct;
      r.ev[r.cnt[1:0]].len    = len;
      r.ev[r.cnt[1:0]].nb     = nb;
      r.ev[r.cnt[1:0]].fits   = fits;
      r.ev[r.cnt[1:0]].reason = reason;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/tls_record_hello_metadata_parser_top.sv
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle unless results back up; a byte causing k results
// (k up to 3) holds the input while the result register drains them in order, and
// a byte causing no result holds nothing. Reset clears all parse state; bytes are
// not parsed until a byte with packet_start arrives.
module tls_record_hello_metadata_parser_top
  import tlsp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // payload_byte[7:0], packet_length[23:8]
  input  logic        s_axis_tuser_i,   // packet_start
  input  logic        s_axis_tlast_i,   // packet_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // rec_type[7:0], length_value[31:8], name_byte[39:32], version_code[55:40],
  // cipher_code[71:56], version_seen[72], sni_seen[73], alpn_seen[74],
  // record_fits[75], stop_reason[76], zero fill[79:77]
  output logic [79:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // event_kind
  output logic        m_axis_tlast_o    // run_last
);

  bundle_t bnd, held;
  ev_t     ev;
  logic    free, req, last;

  assign s_axis_tready_o = free;
  assign req = s_axis_tvalid_i && free;

  tlsp_parse_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .byte_i   (s_axis_tdata_i[7:0]),
    .start_i  (s_axis_tuser_i),
    .plen_i   (s_axis_tdata_i[23:8]),
    .end_i    (s_axis_tlast_i),
    .bundle_o (bnd)
  );

  tlsp_out_ser u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (req),
    .bundle_i (bnd),
    .free_o   (free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .ev_o     (ev),
    .held_o   (held),
    .last_o   (last)
  );

  assign m_axis_tuser_o = ev.kind;
  assign m_axis_tlast_o = last;
  assign m_axis_tdata_o = {3'b000, ev.reason, ev.fits, held.flags[2], held.flags[1],
                           held.flags[0], held.ciph, held.ver, ev.nb, ev.len, ev.ct};

endmodule

FILE: hw/rtl/tlsp_parse_core.sv
// Parse state and per-byte next-state logic of the TLS record parser.
// Depends on tlsp_pkg; produces one event bundle per accepted byte.
module tlsp_parse_core
  import tlsp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  input  logic [15:0] plen_i,
  input  logic        end_i,
  output bundle_t     bundle_o
);

  logic [LENGTH_BITS-1:0] pkt_q, pkt_d;
  phase_e      ph_q, ph_d;
  logic [15:0] rec_q, rec_d;
  logic [31:0] hs_q, hs_d;
  logic [7:0]  fc_q, fc_d;
  logic [23:0] msg_q, msg_d;
  logic [15:0] ebl_q, ebl_d;
  logic [15:0] ext_q, ext_d;
  logic [15:0] et_q, et_d;
  logic [15:0] nbl_q, nbl_d;
  logic [15:0] ver_q, ver_d;
  logic [15:0] ciph_q, ciph_d;
  logic [2:0]  flags_q, flags_d;
  logic        stop_q, stop_d;
  logic [23:0] hl_q, hl_d;

  function automatic logic in_rec(phase_e p);
    logic [30:0] v;
    v = p;
    return |v[30:2];
  endfunction
  function automatic logic in_msg(phase_e p);
    logic [30:0] v;
    v = p;
    return |v[30:5];
  endfunction
  function automatic logic in_block(phase_e p);
    logic [30:0] v;
    v = p;
    return |v[30:21];
  endfunction
  function automatic logic in_ext(phase_e p);
    logic [30:0] v;
    v = p;
    return |v[30:22];
  endfunction

  always_comb begin
    bundle_t     bnd;
    logic [7:0]  t;
    logic [15:0] v16;
    logic [23:0] v24;
    phase_e      p0;
    bnd     = '0;
    t       = '0;
    v16     = '0;
    v24     = '0;
    p0      = ph_q;
    pkt_d   = pkt_q;   ph_d   = ph_q;   rec_d = rec_q;  hs_d  = hs_q;
    fc_d    = fc_q;    msg_d  = msg_q;  ebl_d = ebl_q;  ext_d = ext_q;
    et_d    = et_q;    nbl_d  = nbl_q;  ver_d = ver_q;  ciph_d = ciph_q;
    flags_d = flags_q; stop_d = stop_q; hl_d  = hl_q;

    if (start_i) begin
      pkt_d = plen_i[LENGTH_BITS-1:0];
      ph_d  = (16'(pkt_d) < 16'd5) ? PH_DRAIN : PH_HDR;
      rec_d = '0; hs_d = '0; fc_d = '0; msg_d = '0; ebl_d = '0; ext_d = '0;
      et_d  = '0; nbl_d = '0; ver_d = '0; ciph_d = '0; flags_d = '0;
      stop_d = 1'b0; hl_d = '0;
    end

    if (pkt_d != '0) begin
      pkt_d = pkt_d - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      if (!stop_d && ph_d != PH_DRAIN) begin
        p0 = ph_d;
        if (in_rec(p0) && rec_d != '0) rec_d = rec_d - 16'd1;
        if (in_msg(p0) && msg_d != '0) msg_d = msg_d - 24'd1;
        if (in_block(p0) && ebl_d != '0) ebl_d = ebl_d - 16'd1;
        if (in_ext(p0) && ext_d != '0) ext_d = ext_d - 16'd1;

        case (ph_d)
          PH_HDR: begin
            if (fc_d == 8'd0) hs_d = {byte_i, 24'd0};
            else if (fc_d >= 8'd3) hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d < 8'd4) begin
              fc_d = fc_d + 8'd1;
            end else begin
              fc_d = '0;
              t    = hs_d[31:24];
              v16  = hs_d[15:0];
              if (t < CtMin || t > CtMax) begin
                bnd = push_ev(bnd, EV_STOP, t, 24'(v16), 8'd0, 1'b0, 1'b0);
                stop_d = 1'b1; ph_d = PH_DRAIN;
              end else if (v16 > 16'(pkt_d)) begin
                bnd = push_ev(bnd, EV_RECORD, t, 24'(v16), 8'd0, 1'b0, 1'b0);
                bnd = push_ev(bnd, EV_STOP, t, 24'(v16), 8'd0, 1'b0, 1'b1);
                stop_d = 1'b1; ph_d = PH_DRAIN;
              end else begin
                bnd = push_ev(bnd, EV_RECORD, t, 24'(v16), 8'd0, 1'b1, 1'b0);
                rec_d = v16;
                ph_d  = (t == CtHandshake) ? PH_HHDR : PH_RSKIP;
              end
            end
          end
          PH_HHDR: begin
            if (fc_d == 8'd0) hs_d = {byte_i, 24'd0};
            else hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d < 8'd3) begin
              fc_d = fc_d + 8'd1;
            end else begin
              fc_d = '0;
              v24  = hs_d[23:0];
              if (v24 > 24'(rec_d)) begin
                ph_d = PH_HSKIP;
              end else begin
                msg_d = v24; hl_d = v24;
                t = hs_d[31:24];
                if (t == MsgClientHello && v24 >= ChMin) ph_d = PH_CFIX;
                else if (t == MsgServerHello && v24 >= ShMin) ph_d = PH_SVER;
                else ph_d = PH_MSKIP;
              end
            end
          end
          PH_CFIX: begin
            fc_d = fc_d + 8'd1;
            if (fc_d >= 8'd34) begin fc_d = '0; ph_d = PH_CSIDLEN; end
          end
          PH_CSIDLEN: begin
            nbl_d = 16'(byte_i); fc_d = '0;
            ph_d  = (byte_i != 8'd0) ? PH_CSID : PH_CCSLEN;
          end
          PH_CCOMPLEN: begin
            nbl_d = 16'(byte_i); fc_d = '0;
            ph_d  = (byte_i != 8'd0) ? PH_CCOMP : PH_CEXTLEN;
          end
          PH_CSID, PH_CCS, PH_CCOMP, PH_SSID: begin
            if (nbl_d != '0) nbl_d = nbl_d - 16'd1;
            if (nbl_d == '0) begin
              fc_d = '0;
              case (ph_d)
                PH_CSID:  ph_d = PH_CCSLEN;
                PH_CCS:   ph_d = PH_CCOMPLEN;
                PH_CCOMP: ph_d = PH_CEXTLEN;
                default:  ph_d = PH_SCIPH;
              endcase
            end
          end
          PH_CCSLEN: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              nbl_d = hs_d[15:0]; fc_d = '0;
              ph_d  = (hs_d[15:0] != '0) ? PH_CCS : PH_CCOMPLEN;
            end
          end
          PH_CEXTLEN, PH_SEXTLEN: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0;
              v16  = hs_d[15:0];
              if (24'(v16) > msg_d) ph_d = PH_MSKIP;
              else begin ebl_d = v16; ph_d = PH_XHDR; end
            end
          end
          PH_SVER: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0; ver_d = hs_d[15:0]; flags_d[0] = 1'b1; ph_d = PH_SRAND;
            end
          end
          PH_SRAND: begin
            fc_d = fc_d + 8'd1;
            if (fc_d >= 8'd32) begin fc_d = '0; ph_d = PH_SSIDLEN; end
          end
          PH_SSIDLEN: begin
            if (24'(byte_i) > msg_d) begin
              ph_d = PH_MSKIP;
            end else begin
              nbl_d = 16'(byte_i); fc_d = '0;
              ph_d  = (byte_i != 8'd0) ? PH_SSID : PH_SCIPH;
            end
          end
          PH_SCIPH: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0; ciph_d = hs_d[15:0]; ph_d = PH_SCOMP;
            end
          end
          PH_SCOMP: begin
            ph_d = PH_SEXTLEN; fc_d = '0;
          end
          PH_XHDR: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            fc_d = fc_d + 8'd1;
            if (fc_d == 8'd2) et_d = hs_d[15:0];
            if (fc_d >= 8'd4) begin
              fc_d = '0;
              v16  = hs_d[15:0];
              if (v16 > ebl_d) begin
                ph_d = PH_MSKIP;
              end else begin
                ext_d = v16;
                t     = hs_d[31:24];
                ph_d  = PH_XSKIP;
                if (t == MsgClientHello) begin
                  if (et_d == ExtSni && v16 >= 16'd5) ph_d = PH_NLIST;
                  else if (et_d == ExtAlpn && v16 >= 16'd2) ph_d = PH_ALIST;
                end else if (t == MsgServerHello && et_d == ExtSupVer && v16 >= 16'd2) begin
                  ph_d = PH_VSEL;
                end
              end
            end
          end
          PH_NLIST: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0;
              ph_d = (hs_d[15:0] >= 16'd3) ? PH_NTYPE : PH_XSKIP;
            end
          end
          PH_NTYPE: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            ph_d = PH_NLEN; fc_d = '0;
          end
          PH_NLEN: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0;
              t    = hs_d[23:16];
              v16  = hs_d[15:0];
              // name must sit wholly inside its extension
              if (t == 8'd0 && v16 != '0 && v16 < SniLimit && v16 <= ext_d) begin
                nbl_d = v16; ph_d = PH_NNAME;
              end else begin
                ph_d = PH_XSKIP;
              end
            end
          end
          PH_NNAME, PH_ANAME: begin
            if (ph_d == PH_NNAME) begin
              flags_d[1] = 1'b1;
              bnd = push_ev(bnd, EV_SNI, 8'd0, 24'd0, byte_i, 1'b0, 1'b0);
            end else begin
              flags_d[2] = 1'b1;
              bnd = push_ev(bnd, EV_ALPN, 8'd0, 24'd0, byte_i, 1'b0, 1'b0);
            end
            if (nbl_d != '0) nbl_d = nbl_d - 16'd1;
            if (nbl_d == '0) ph_d = PH_XSKIP;
          end
          PH_ALIST: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0;
              v16  = hs_d[15:0];
              if (v16 != '0 && v16 <= ext_d) begin nbl_d = v16; ph_d = PH_ALEN; end
              else ph_d = PH_XSKIP;
            end
          end
          PH_ALEN: begin
            if (byte_i != 8'd0 && byte_i < AlpnLimit && 16'(byte_i) < nbl_d) begin
              nbl_d = 16'(byte_i); ph_d = PH_ANAME;
            end else begin
              ph_d = PH_XSKIP;
            end
          end
          PH_VSEL: begin
            hs_d = {hs_d[31:24], hs_d[15:0], byte_i};
            if (fc_d == 8'd0) begin
              fc_d = 8'd1;
            end else begin
              fc_d = '0; ver_d = hs_d[15:0]; ph_d = PH_XSKIP;
            end
          end
          default: ;
        endcase

        // unwind finished containers, innermost first
        if (in_ext(ph_d) && ext_d == '0) begin ph_d = PH_XHDR; fc_d = '0; end
        if (in_block(ph_d) && ebl_d == '0) ph_d = PH_MSKIP;
        if (ph_d == PH_XHDR && fc_d == '0 && ebl_d < 16'd4) ph_d = PH_MSKIP;
        if (in_msg(ph_d) && msg_d == '0) begin
          t = hs_d[31:24];
          if (t == MsgClientHello) bnd = push_ev(bnd, EV_CHELLO, 8'd0, hl_d, 8'd0, 1'b0, 1'b0);
          else if (t == MsgServerHello)
            bnd = push_ev(bnd, EV_SHELLO, 8'd0, hl_d, 8'd0, 1'b0, 1'b0);
          ph_d = PH_HHDR; fc_d = '0;
        end
        if (ph_d == PH_HHDR && fc_d == '0 && rec_d < 16'd4) ph_d = PH_HSKIP;
        if (in_rec(ph_d) && rec_d == '0) begin ph_d = PH_HDR; fc_d = '0; end
        if (ph_d == PH_HDR && fc_d == '0 && 16'(pkt_d) < 16'd5) ph_d = PH_DRAIN;
      end
    end

    if (end_i) begin
      bnd   = push_ev(bnd, EV_PKTDONE, 8'd0, 24'd0, 8'd0, 1'b0, 1'b0);
      ph_d  = PH_DRAIN;
      pkt_d = '0;
    end

    bnd.ver   = ver_d;
    bnd.ciph  = ciph_d;
    bnd.flags = flags_d;
    bundle_o  = bnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0; ph_q <= PH_DRAIN; rec_q <= '0; hs_q <= '0; fc_q <= '0;
      msg_q <= '0; ebl_q <= '0; ext_q <= '0; et_q <= '0; nbl_q <= '0;
      ver_q <= '0; ciph_q <= '0; flags_q <= '0; stop_q <= 1'b0; hl_q <= '0;
    end else if (req_i) begin
      pkt_q <= pkt_d; ph_q <= ph_d; rec_q <= rec_d; hs_q <= hs_d; fc_q <= fc_d;
      msg_q <= msg_d; ebl_q <= ebl_d; ext_q <= ext_d; et_q <= et_d; nbl_q <= nbl_d;
      ver_q <= ver_d; ciph_q <= ciph_d; flags_q <= flags_d; stop_q <= stop_d;
      hl_q <= hl_d;
    end
  end

endmodule

FILE: hw/rtl/tlsp_out_ser.sv
// Result register and serializer: holds one event bundle, hands out its events.
// Depends on tlsp_pkg.
module tlsp_out_ser
  import tlsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output ev_t     ev_o,
  output bundle_t held_o,
  output logic    last_o
);

  bundle_t    bnd_q;
  logic [1:0] idx_q;
  logic       valid_q;
  logic       take;

  assign ev_o    = bnd_q.ev[idx_q];
  assign held_o  = bnd_q;
  assign last_o  = ({1'b0, idx_q} + 3'd1) == bnd_q.cnt;
  assign valid_o = valid_q;
  assign take    = valid_q && ready_i;
  // next request may enter while the final event of the current one leaves
  assign free_o  = !valid_q || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= bundle_i.cnt != 3'd0;
      idx_q   <= '0;
    end else if (take) begin
      if (last_o) valid_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) bnd_q <= bundle_i;
  end

endmodule

FILE: hw/rtl/tlsp_checker.sv
// Port-level checks of the TLS record parser, bound to the top level.
// Depends on tlsp_pkg and tls_record_hello_metadata_parser_top_assert.svh.
`include "tls_record_hello_metadata_parser_top_assert.svh"
module tlsp_checker
  import tlsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_i,
  input logic [2:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  `TLSP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
  `TLSP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_i)
  `TLSP_ASSERT(a_done_last, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i == EV_PKTDONE |-> m_axis_tlast_i)
  `TLSP_ASSERT(a_sni_flag, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i == EV_SNI |-> m_axis_tdata_i[73])

endmodule

bind tls_record_hello_metadata_parser_top tlsp_checker u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
